[hdl/msvf_pkg.sv]
package msvf_pkg;

  // Shared multiplier datapath widths
  localparam int MC_W  = 34;             // signed multiplicand
  localparam int DIG_W = 4;              // multiplier digit per cycle
  localparam int MPL_W = 16;             // unsigned multiplier, four digits
  localparam int ACC_W = MC_W + MPL_W;   // product accumulator
  localparam int CNT_W = 3;
  localparam logic [CNT_W-1:0] DIGITS_FULL = CNT_W'(MPL_W / DIG_W);
  localparam logic [CNT_W-1:0] DIGITS_ONE  = CNT_W'(1);

  localparam int MIX_W   = 18;
  localparam int OUT_W   = 16;
  localparam int STATE_W = 24;
  localparam int OP_W    = 32;
  localparam int CFG_W   = 15;
  localparam int LIM_W   = 17;

  localparam logic [LIM_W-1:0] FULL_LIMIT = LIM_W'(50000);
  localparam logic [LIM_W-1:0] BAL_LIMIT  = LIM_W'(40000);
  localparam logic [LIM_W-1:0] INC_LIMIT  = LIM_W'(8192);
  localparam logic [LIM_W-1:0] FB_LIMIT   = LIM_W'(4096);

  typedef logic signed [ACC_W-1:0] wide_t;

  typedef enum logic [2:0] {
    REG_QUALITY = 3'd0,
    REG_COEFF   = 3'd1,
    REG_RES     = 3'd2,
    REG_ROUTE   = 3'd3,
    REG_MODE    = 3'd4
  } cfg_reg_t;

  localparam logic [1:0] QM_FULL = 2'd0;
  localparam logic [1:0] QM_BAL  = 2'd1;
  localparam logic [1:0] QM_FAST = 2'd2;

  function automatic wide_t clamp_sym(input wide_t v, input logic [LIM_W-1:0] lim);
    wide_t lim_s;
    lim_s = $signed({{(ACC_W-LIM_W){1'b0}}, lim});
    if (v > lim_s) begin
      return lim_s;
    end else if (v < -lim_s) begin
      return -lim_s;
    end
    return v;
  endfunction

  function automatic logic signed [OUT_W-1:0] sat16(input wide_t v);
    if (v > 50'sd32767) begin
      return 16'sh7fff;
    end else if (v < -50'sd32768) begin
      return 16'sh8000;
    end
    return v[OUT_W-1:0];
  endfunction

endpackage

[hdl/multimode_state_variable_filter_top.sv]
// Multimode state-variable filter. One signed 18-bit mix sample goes in on
// s_axis, one saturated 16-bit sample comes out on m_axis. Quality mode 0 (and
// 3) runs the full state-variable filter, 1 the balanced one, 2 a one-pole
// lowpass. All products go through one shared multiplier that takes a 4-bit
// digit of the unsigned operand per cycle, so the multiply chain sets how long
// the input stays closed: a filter sample keeps it closed through setup, two
// 4-digit multiplies with their update steps, one 1-digit resonance multiply,
// the final step and the output write; a one-pole sample through setup, one
// 4-digit multiply, its update and the write; and a bypassed sample (no mode
// bit or no routing bit in full or balanced) only through the write. The result turns
// valid at the edge that reopens the input; a stalled result in the output
// register holds the block back until it is taken. Input is taken only while
// the block is idle; a finished sample sits in the output register, so the
// next input can be taken while it waits. Registers are written through
// cfg_we/cfg_addr/cfg_data and must only be changed while the block is idle.
module multimode_state_variable_filter_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [17:0] mix_in
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] sample_out
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [msvf_pkg::CFG_W-1:0] cfg_data
);
  import msvf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_MUL, S_INC1, S_INC2, S_FINAL, S_ONEPOLE, S_WRITE
  } state_t;

  typedef enum logic [1:0] {PH_H, PH_B, PH_FB, PH_OP} phase_t;

  state_t state;
  phase_t phase;

  logic [1:0]       quality_mode;
  logic [CFG_W-1:0] filter_coeff;
  logic [3:0]       resonance;
  logic [3:0]       route_mask;
  logic [2:0]       mode_bits;

  logic signed [STATE_W-1:0] band_state;
  logic signed [STATE_W-1:0] low_state;
  logic signed [OP_W-1:0]    onepole_state;

  logic signed [MIX_W-1:0]   mix;
  logic signed [STATE_W-1:0] vb;
  logic signed [STATE_W-1:0] vl;
  logic signed [MIX_W-1:0]   h;
  logic signed [MC_W-1:0]    mcand;
  logic [MPL_W-1:0]          mplier;
  logic [CNT_W-1:0]          dcnt;
  wide_t                     acc;
  logic signed [OUT_W-1:0]   result;

  logic                      is_fast;
  logic                      is_full;
  logic                      bypass;
  logic [LIM_W-1:0]          lim;
  logic signed [MIX_W-1:0]   mix_in;
  logic signed [MC_W+DIG_W:0] dig_prod;
  wide_t                     acc_next;
  wide_t                     vb_c;
  wide_t                     vl_c;
  wide_t                     h_wide;
  logic signed [MIX_W-1:0]   h_next;
  wide_t                     inc_c;
  logic signed [STATE_W-1:0] vb_new;
  logic signed [STATE_W-1:0] vl_new;
  wide_t                     fb_c;
  wide_t                     svf_sum;
  wide_t                     x_op;
  wide_t                     op_diff;
  logic signed [OP_W-1:0]    y_new;

  function automatic wide_t shr_sh(input wide_t v, input logic full);
    return full ? (v >>> 3) : (v >>> 4);
  endfunction

  always_comb begin
    is_fast = (quality_mode == QM_FAST);
    is_full = (quality_mode != QM_BAL);
    lim     = is_full ? FULL_LIMIT : BAL_LIMIT;
    mix_in  = $signed(s_axis_tdata[MIX_W-1:0]);
    bypass  = (mode_bits == 3'd0) || (route_mask == 4'd0);

    // one digit of the multiplier per cycle, most significant first
    dig_prod = mcand * $signed({1'b0, mplier[MPL_W-1 -: DIG_W]});
    acc_next = (acc <<< DIG_W) + ACC_W'(dig_prod);

    // integrators are clamped at the start of every filter step
    vb_c   = clamp_sym(ACC_W'(band_state), lim);
    vl_c   = clamp_sym(ACC_W'(low_state), lim);
    h_wide = (ACC_W'(mix) >>> 3) - shr_sh(vl_c, is_full) - shr_sh(vb_c, is_full);
    h_next = is_full ? MIX_W'(sat16(h_wide)) : h_wide[MIX_W-1:0];

    inc_c  = is_full ? clamp_sym(acc >>> 14, INC_LIMIT) : (acc >>> 14);
    vb_new = vb + inc_c[STATE_W-1:0];
    vl_new = vl + inc_c[STATE_W-1:0];

    fb_c    = clamp_sym(is_full ? (acc >>> 7) : (acc >>> 8), FB_LIMIT);
    svf_sum = fb_c;
    if (mode_bits[0]) begin
      svf_sum = svf_sum + shr_sh(ACC_W'(vl), is_full);
    end
    if (mode_bits[1]) begin
      svf_sum = svf_sum + shr_sh(ACC_W'(vb), is_full);
    end
    if (mode_bits[2]) begin
      svf_sum = svf_sum + ACC_W'(h);
    end

    x_op    = ACC_W'(mix) >>> 2;
    op_diff = x_op - ACC_W'(onepole_state);
    // accumulator wraps to 32 bits
    y_new   = onepole_state + acc[OP_W+11:12];
  end

  assign s_axis_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      phase         <= PH_H;
      dcnt          <= '0;
      quality_mode  <= '0;
      filter_coeff  <= '0;
      resonance     <= '0;
      route_mask    <= '0;
      mode_bits     <= '0;
      band_state    <= '0;
      low_state     <= '0;
      onepole_state <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_QUALITY: quality_mode <= cfg_data[1:0];
          REG_COEFF:   filter_coeff <= cfg_data;
          REG_RES:     resonance    <= cfg_data[3:0];
          REG_ROUTE:   route_mask   <= cfg_data[3:0];
          REG_MODE:    mode_bits    <= cfg_data[2:0];
          default: ;
        endcase
      end

      // S_WRITE refills the output register itself
      if (m_axis_tvalid && m_axis_tready && (state != S_WRITE)) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            mix <= mix_in;
            if (!is_fast && bypass) begin
              result <= sat16(ACC_W'(mix_in));
              state  <= S_WRITE;
            end else begin
              state <= S_PREP;
            end
          end
        end
        S_PREP: begin
          acc  <= '0;
          dcnt <= DIGITS_FULL;
          if (is_fast) begin
            mcand  <= op_diff[MC_W-1:0];
            mplier <= {3'b000, filter_coeff[CFG_W-1:2]};
            phase  <= PH_OP;
          end else begin
            vb     <= vb_c[STATE_W-1:0];
            vl     <= vl_c[STATE_W-1:0];
            h      <= h_next;
            mcand  <= MC_W'(h_next);
            mplier <= {1'b0, filter_coeff};
            phase  <= PH_H;
          end
          state <= S_MUL;
        end
        S_MUL: begin
          acc    <= acc_next;
          mplier <= mplier << DIG_W;
          dcnt   <= dcnt - 1'b1;
          if (dcnt == DIGITS_ONE) begin
            case (phase)
              PH_H:    state <= S_INC1;
              PH_B:    state <= S_INC2;
              PH_FB:   state <= S_FINAL;
              default: state <= S_ONEPOLE;
            endcase
          end
        end
        S_INC1: begin
          vb     <= vb_new;
          mcand  <= MC_W'(vb_new);
          mplier <= {1'b0, filter_coeff};
          acc    <= '0;
          dcnt   <= DIGITS_FULL;
          phase  <= PH_B;
          state  <= S_MUL;
        end
        S_INC2: begin
          vl     <= vl_new;
          mcand  <= MC_W'(vb);
          // resonance sits in the top digit: a single step forms vb * resonance
          mplier <= {resonance, {(MPL_W-DIG_W){1'b0}}};
          acc    <= '0;
          dcnt   <= DIGITS_ONE;
          phase  <= PH_FB;
          state  <= S_MUL;
        end
        S_FINAL: begin
          band_state <= vb;
          low_state  <= vl;
          result     <= sat16(svf_sum <<< 2);
          state      <= S_WRITE;
        end
        S_ONEPOLE: begin
          onepole_state <= y_new;
          result        <= sat16(ACC_W'(y_new) <<< 2);
          state         <= S_WRITE;
        end
        S_WRITE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata  <= result;
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[hdl/msvf_checker.sv]
module msvf_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // one sample in flight: input closes right after an item is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready stayed high after an accepted item");

  // output valid does not rise at the edge that takes an item; each result first passes the write state
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
    else $error("output valid rose one cycle after input accept");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid set right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output item changed or dropped");

endmodule

bind multimode_state_variable_filter_top msvf_checker u_msvf_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
